[src/qau_pkg.sv]
`default_nettype none
package qau_pkg;

   typedef logic [2:0] op_type;

   localparam op_type OP_MUL       = 3'd0;
   localparam op_type OP_ADD       = 3'd1;
   localparam op_type OP_SUB       = 3'd2;
   localparam op_type OP_CONJ      = 3'd3;
   localparam op_type OP_SCALE     = 3'd4;
   localparam op_type OP_NORM      = 3'd5;
   localparam op_type OP_NORMALIZE = 3'd6;

   // operand word plus the norm once it is known; component 0 is the real part
   typedef struct packed {
      op_type           op;
      logic [3:0][31:0] p;
      logic [3:0][31:0] q;
      logic [32:0]      n;
   } ctx_type;

   // normalize result from the divider
   typedef struct packed {
      logic [3:0][31:0] r;
      logic             sat;
      logic             zn;
   } nres_type;

   typedef struct packed {
      logic [31:0] v;
      logic        sat;
   } clip_type;

   function automatic clip_type clip66(input logic signed [65:0] x);
      clip_type c;
      if (x > 66'sd2147483647) begin
         c.v   = 32'h7fff_ffff;
         c.sat = 1'b1;
      end else if (x < -66'sd2147483648) begin
         c.v   = 32'h8000_0000;
         c.sat = 1'b1;
      end else begin
         c.v   = x[31:0];
         c.sat = 1'b0;
      end
      return c;
   endfunction

endpackage
`default_nettype wire

[src/qau_req_if.sv]
`default_nettype none
interface qau_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         op;
   logic signed [31:0] p_w;
   logic signed [31:0] p_x;
   logic signed [31:0] p_y;
   logic signed [31:0] p_z;
   logic signed [31:0] q_w;
   logic signed [31:0] q_x;
   logic signed [31:0] q_y;
   logic signed [31:0] q_z;

   modport source(output valid, op, p_w, p_x, p_y, p_z, q_w, q_x, q_y, q_z, input ready);
   modport sink(input valid, op, p_w, p_x, p_y, p_z, q_w, q_x, q_y, q_z, output ready);
endinterface
`default_nettype wire

[src/qau_rsp_if.sv]
`default_nettype none
interface qau_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] r_w;
   logic signed [31:0] r_x;
   logic signed [31:0] r_y;
   logic signed [31:0] r_z;
   logic               saturated;
   logic               zero_norm;

   modport source(output valid, r_w, r_x, r_y, r_z, saturated, zero_norm, input ready);
   modport sink(input valid, r_w, r_x, r_y, r_z, saturated, zero_norm, output ready);
endinterface
`default_nettype wire

[src/qau_norm.sv]
`default_nettype none
// squares, sum, 32-step pipelined square root, round to nearest
module qau_norm (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire qau_pkg::ctx_type in_ctx,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output qau_pkg::ctx_type      out_ctx
);

   localparam int SQ_STAGES = 32;
   localparam int N_ST      = SQ_STAGES + 3;

   logic [N_ST-1:0] v_ff;
   logic [N_ST-1:0] v_src;
   logic [N_ST:0]   rdy;

   assign rdy[N_ST] = out_ready;
   for (genvar k = 0; k < N_ST; k++) begin : g_rdy
      assign rdy[k] = !v_ff[k] || rdy[k+1];
   end
   assign in_ready = rdy[0];
   assign v_src    = {v_ff[N_ST-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < N_ST; k++) begin
            if (rdy[k]) v_ff[k] <= v_src[k];
         end
      end
   end

   // stage 0: squares of magnitudes
   logic [31:0]      mag [4];
   logic [63:0]      sq_ff [4];
   qau_pkg::ctx_type ctx0_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         mag[i] = in_ctx.p[i][31] ? (~in_ctx.p[i] + 32'd1) : in_ctx.p[i];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         ctx0_ff <= in_ctx;
         for (int i = 0; i < 4; i++) sq_ff[i] <= {32'd0, mag[i]} * {32'd0, mag[i]};
      end
   end

   // stage 1: exact sum, carry out of 64 bits forces norm 2^32
   logic [65:0]      sum_in;
   logic [63:0]      s1_ff;
   logic             cy1_ff;
   qau_pkg::ctx_type ctx1_ff;

   assign sum_in = {2'd0, sq_ff[0]} + {2'd0, sq_ff[1]} + {2'd0, sq_ff[2]} + {2'd0, sq_ff[3]};

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         ctx1_ff <= ctx0_ff;
         s1_ff   <= sum_in[63:0];
         cy1_ff  <= sum_in[65:64] != 2'd0;
      end
   end

   // square root, one result bit per stage
   logic [33:0]      rem_ff  [SQ_STAGES];
   logic [31:0]      root_ff [SQ_STAGES];
   logic [63:0]      sh_ff   [SQ_STAGES];
   logic             cy_ff   [SQ_STAGES];
   qau_pkg::ctx_type ctxq_ff [SQ_STAGES];

   for (genvar j = 0; j < SQ_STAGES; j++) begin : g_sqrt
      logic [33:0]      prev_rem;
      logic [31:0]      prev_root;
      logic [63:0]      prev_sh;
      logic             prev_cy;
      qau_pkg::ctx_type prev_ctx;
      logic [35:0]      pre;
      logic [35:0]      trial;
      logic             fit;

      if (j == 0) begin : g_first
         assign prev_rem  = '0;
         assign prev_root = '0;
         assign prev_sh   = s1_ff;
         assign prev_cy   = cy1_ff;
         assign prev_ctx  = ctx1_ff;
      end else begin : g_next
         assign prev_rem  = rem_ff[j-1];
         assign prev_root = root_ff[j-1];
         assign prev_sh   = sh_ff[j-1];
         assign prev_cy   = cy_ff[j-1];
         assign prev_ctx  = ctxq_ff[j-1];
      end

      assign pre   = {prev_rem, prev_sh[63:62]};
      assign trial = {2'b00, prev_root, 2'b01};
      assign fit   = pre >= trial;

      always_ff @(posedge clock) begin
         if (rdy[2+j]) begin
            rem_ff[j]  <= fit ? 34'(pre - trial) : pre[33:0];
            root_ff[j] <= {prev_root[30:0], fit};
            sh_ff[j]   <= {prev_sh[61:0], 2'b00};
            cy_ff[j]   <= prev_cy;
            ctxq_ff[j] <= prev_ctx;
         end
      end
   end

   // final stage: round up when remainder exceeds root
   logic [32:0]      r_rnd;
   qau_pkg::ctx_type ctx_out_in;
   qau_pkg::ctx_type ctx_out_ff;

   assign r_rnd = {1'b0, root_ff[SQ_STAGES-1]}
                + 33'(rem_ff[SQ_STAGES-1] > {2'b00, root_ff[SQ_STAGES-1]});

   always_comb begin
      ctx_out_in   = ctxq_ff[SQ_STAGES-1];
      ctx_out_in.n = cy_ff[SQ_STAGES-1] ? 33'h1_0000_0000 : r_rnd;
   end

   always_ff @(posedge clock) begin
      if (rdy[N_ST-1]) begin
         ctx_out_ff <= ctx_out_in;
      end
   end

   assign out_valid = v_ff[N_ST-1];
   assign out_ctx   = ctx_out_ff;

endmodule
`default_nettype wire

[src/qau_div.sv]
`default_nettype none
// four-lane pipelined restoring divide: (|p_i| << FRAC_BITS + n/2) / n
module qau_div #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire qau_pkg::ctx_type in_ctx,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output qau_pkg::ctx_type      out_ctx,
   output qau_pkg::nres_type     out_nres
);

   localparam int QW     = 33;
   localparam int DW     = 32 + FRAC_BITS;
   localparam int N_IT   = QW;
   localparam int N_ST   = N_IT + 2;

   logic [N_ST-1:0] v_ff;
   logic [N_ST-1:0] v_src;
   logic [N_ST:0]   rdy;

   assign rdy[N_ST] = out_ready;
   for (genvar k = 0; k < N_ST; k++) begin : g_rdy
      assign rdy[k] = !v_ff[k] || rdy[k+1];
   end
   assign in_ready = rdy[0];
   assign v_src    = {v_ff[N_ST-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < N_ST; k++) begin
            if (rdy[k]) v_ff[k] <= v_src[k];
         end
      end
   end

   // prep: dividend, overflow test against n << 33, first partial remainder
   logic [31:0]      mag  [4];
   logic [DW-1:0]    dvd  [4];
   logic [QW-1:0]    rem0_ff [4];
   logic [QW-1:0]    dq0_ff  [4];
   logic [3:0]       ovf0_ff;
   logic [3:0]       neg0_ff;
   qau_pkg::ctx_type ctx0_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         mag[i] = in_ctx.p[i][31] ? (~in_ctx.p[i] + 32'd1) : in_ctx.p[i];
         dvd[i] = (DW'(mag[i]) << FRAC_BITS) + DW'(in_ctx.n[32:1]);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         ctx0_ff <= in_ctx;
         for (int i = 0; i < 4; i++) begin
            rem0_ff[i] <= QW'(dvd[i] >> QW);
            dq0_ff[i]  <= dvd[i][QW-1:0];
            ovf0_ff[i] <= 66'(dvd[i]) >= {in_ctx.n, 33'd0};
            neg0_ff[i] <= in_ctx.p[i][31];
         end
      end
   end

   // iterations: dividend bits shift out of dq at the top, quotient bits in at the bottom
   logic [QW-1:0]    rem_ff [N_IT][4];
   logic [QW-1:0]    dq_ff  [N_IT][4];
   logic [3:0]       ovf_ff [N_IT];
   logic [3:0]       neg_ff [N_IT];
   qau_pkg::ctx_type ctx_ff [N_IT];

   for (genvar j = 0; j < N_IT; j++) begin : g_it
      logic [QW-1:0]    prev_rem [4];
      logic [QW-1:0]    prev_dq  [4];
      logic [3:0]       prev_ovf;
      logic [3:0]       prev_neg;
      qau_pkg::ctx_type prev_ctx;
      logic [QW:0]      pre [4];
      logic [3:0]       fit;

      if (j == 0) begin : g_first
         assign prev_rem = rem0_ff;
         assign prev_dq  = dq0_ff;
         assign prev_ovf = ovf0_ff;
         assign prev_neg = neg0_ff;
         assign prev_ctx = ctx0_ff;
      end else begin : g_next
         assign prev_rem = rem_ff[j-1];
         assign prev_dq  = dq_ff[j-1];
         assign prev_ovf = ovf_ff[j-1];
         assign prev_neg = neg_ff[j-1];
         assign prev_ctx = ctx_ff[j-1];
      end

      always_comb begin
         for (int i = 0; i < 4; i++) begin
            pre[i] = {prev_rem[i], prev_dq[i][QW-1]};
            fit[i] = pre[i] >= {1'b0, prev_ctx.n};
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[1+j]) begin
            for (int i = 0; i < 4; i++) begin
               rem_ff[j][i] <= fit[i] ? QW'(pre[i] - {1'b0, prev_ctx.n}) : pre[i][QW-1:0];
               dq_ff[j][i]  <= {prev_dq[i][QW-2:0], fit[i]};
            end
            ovf_ff[j] <= prev_ovf;
            neg_ff[j] <= prev_neg;
            ctx_ff[j] <= prev_ctx;
         end
      end
   end

   // final: restore sign, clip, zero-norm case
   qau_pkg::nres_type nres_in;
   qau_pkg::nres_type nres_ff;
   qau_pkg::ctx_type  ctx_out_ff;
   logic [QW-1:0]     quo [4];
   logic [3:0]        lane_sat;

   always_comb begin
      nres_in = '0;
      lane_sat = '0;
      for (int i = 0; i < 4; i++) begin
         quo[i] = dq_ff[N_IT-1][i];
         if (neg_ff[N_IT-1][i]) begin
            if (ovf_ff[N_IT-1][i] || quo[i] > 33'h0_8000_0000) begin
               nres_in.r[i] = 32'h8000_0000;
               lane_sat[i]  = 1'b1;
            end else begin
               nres_in.r[i] = ~quo[i][31:0] + 32'd1;
            end
         end else begin
            if (ovf_ff[N_IT-1][i] || quo[i][32:31] != 2'd0) begin
               nres_in.r[i] = 32'h7fff_ffff;
               lane_sat[i]  = 1'b1;
            end else begin
               nres_in.r[i] = quo[i][31:0];
            end
         end
      end
      nres_in.sat = |lane_sat;
      if (ctx_ff[N_IT-1].n == 33'd0) begin
         nres_in    = '0;
         nres_in.zn = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[N_ST-1]) begin
         nres_ff    <= nres_in;
         ctx_out_ff <= ctx_ff[N_IT-1];
      end
   end

   assign out_valid = v_ff[N_ST-1];
   assign out_ctx   = ctx_out_ff;
   assign out_nres  = nres_ff;

endmodule
`default_nettype wire

[src/qau_alu.sv]
`default_nettype none
// products, sums, rounding, opcode select and saturation
module qau_alu #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire qau_pkg::ctx_type  in_ctx,
   input  wire qau_pkg::nres_type in_nres,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output logic [3:0][31:0]       out_r,
   output logic                   out_sat,
   output logic                   out_zn
);

   localparam int N_ST = 3;
   localparam logic signed [65:0] HALF = 66'sd1 <<< (FRAC_BITS - 1);

   logic [N_ST-1:0] v_ff;
   logic [N_ST-1:0] v_src;
   logic [N_ST:0]   rdy;

   assign rdy[N_ST] = out_ready;
   for (genvar k = 0; k < N_ST; k++) begin : g_rdy
      assign rdy[k] = !v_ff[k] || rdy[k+1];
   end
   assign in_ready = rdy[0];
   assign v_src    = {v_ff[N_ST-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < N_ST; k++) begin
            if (rdy[k]) v_ff[k] <= v_src[k];
         end
      end
   end

   // stage 0: sixteen exact products, linear ops
   logic signed [63:0] prod_ff [4][4];
   logic signed [33:0] lin_in  [4];
   logic signed [33:0] lin0_ff [4];
   qau_pkg::ctx_type   ctx0_ff;
   qau_pkg::nres_type  nres0_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         case (in_ctx.op)
            qau_pkg::OP_ADD:
               lin_in[i] = 34'($signed(in_ctx.p[i])) + 34'($signed(in_ctx.q[i]));
            qau_pkg::OP_SUB:
               lin_in[i] = 34'($signed(in_ctx.p[i])) - 34'($signed(in_ctx.q[i]));
            qau_pkg::OP_CONJ:
               lin_in[i] = (i == 0) ? 34'($signed(in_ctx.p[i]))
                                    : -34'($signed(in_ctx.p[i]));
            default:
               lin_in[i] = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         ctx0_ff  <= in_ctx;
         nres0_ff <= in_nres;
         for (int a = 0; a < 4; a++) begin
            lin0_ff[a] <= lin_in[a];
            for (int b = 0; b < 4; b++) begin
               prod_ff[a][b] <= $signed(in_ctx.p[a]) * $signed(in_ctx.q[b]);
            end
         end
      end
   end

   // stage 1: Hamilton sums, or the single scale term
   logic signed [65:0] e [4][4];
   logic signed [65:0] sum_in  [4];
   logic signed [65:0] sum_ff  [4];
   logic signed [33:0] lin1_ff [4];
   qau_pkg::ctx_type   ctx1_ff;
   qau_pkg::nres_type  nres1_ff;

   always_comb begin
      for (int a = 0; a < 4; a++) begin
         for (int b = 0; b < 4; b++) e[a][b] = 66'(prod_ff[a][b]);
      end
      if (ctx0_ff.op == qau_pkg::OP_MUL) begin
         sum_in[0] = e[0][0] - e[1][1] - e[2][2] - e[3][3];
         sum_in[1] = e[0][1] + e[1][0] + e[2][3] - e[3][2];
         sum_in[2] = e[0][2] - e[1][3] + e[2][0] + e[3][1];
         sum_in[3] = e[0][3] + e[1][2] - e[2][1] + e[3][0];
      end else begin
         for (int i = 0; i < 4; i++) sum_in[i] = e[i][0];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         ctx1_ff  <= ctx0_ff;
         nres1_ff <= nres0_ff;
         for (int i = 0; i < 4; i++) begin
            sum_ff[i]  <= sum_in[i];
            lin1_ff[i] <= lin0_ff[i];
         end
      end
   end

   // stage 2: round half up, select, clip
   logic signed [65:0] val [4];
   qau_pkg::clip_type  clp [4];
   logic [3:0][31:0]   r_in;
   logic               sat_in;
   logic               zn_in;
   logic [3:0][31:0]   r_ff;
   logic               sat_ff;
   logic               zn_ff;

   always_comb begin
      r_in   = '0;
      sat_in = 1'b0;
      zn_in  = 1'b0;
      for (int i = 0; i < 4; i++) begin
         case (ctx1_ff.op) inside
            qau_pkg::OP_MUL, qau_pkg::OP_SCALE:
               val[i] = (sum_ff[i] + HALF) >>> FRAC_BITS;
            qau_pkg::OP_ADD, qau_pkg::OP_SUB, qau_pkg::OP_CONJ:
               val[i] = 66'(lin1_ff[i]);
            qau_pkg::OP_NORM:
               val[i] = (i == 0) ? {33'd0, ctx1_ff.n} : '0;
            default:
               val[i] = '0;
         endcase
         clp[i]  = qau_pkg::clip66(val[i]);
         r_in[i] = clp[i].v;
         sat_in  = sat_in | clp[i].sat;
      end
      if (ctx1_ff.op == qau_pkg::OP_NORMALIZE) begin
         r_in   = nres1_ff.r;
         sat_in = nres1_ff.sat;
         zn_in  = nres1_ff.zn;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         r_ff   <= r_in;
         sat_ff <= sat_in;
         zn_ff  <= zn_in;
      end
   end

   assign out_valid = v_ff[N_ST-1];
   assign out_r     = r_ff;
   assign out_sat   = sat_ff;
   assign out_zn    = zn_ff;

endmodule
`default_nettype wire

[src/quaternion_arithmetic_unit.sv]
// Pipeline: an accepted request word passes the norm/square root, divide and
// multiply/round/select sections in that order on its way to its response word.
// Throughput: one word per cycle; every stage holds while its successor is full.
// Reset: synchronous, active high; clears all stage valid bits, data is unreset.
`default_nettype none
module quaternion_arithmetic_unit #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   qau_req_if.sink   req_bus,
   qau_rsp_if.source rsp_bus
);

   // Every word runs the full pipe whatever its opcode, so order is kept
   // without any reorder logic: norm first, then the normalize divider,
   // then the product/sum ALU which picks the answer for the opcode.

   qau_pkg::ctx_type  req_ctx;
   qau_pkg::ctx_type  norm_ctx;
   qau_pkg::ctx_type  div_ctx;
   qau_pkg::nres_type div_nres;
   logic              norm_valid;
   logic              norm_ready;
   logic              div_valid;
   logic              div_ready;
   logic [3:0][31:0]  alu_r;

   always_comb begin
      req_ctx.op = req_bus.op;
      req_ctx.p  = {req_bus.p_z, req_bus.p_y, req_bus.p_x, req_bus.p_w};
      req_ctx.q  = {req_bus.q_z, req_bus.q_y, req_bus.q_x, req_bus.q_w};
      req_ctx.n  = '0;
   end

   // norm of p: squares, sum, square root with round to nearest
   qau_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_ctx    (req_ctx),
      .out_valid (norm_valid),
      .out_ready (norm_ready),
      .out_ctx   (norm_ctx)
   );

   // per-component divide by the norm; zero norm flagged here
   qau_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (norm_valid),
      .in_ready  (norm_ready),
      .in_ctx    (norm_ctx),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_ctx   (div_ctx),
      .out_nres  (div_nres)
   );

   // Hamilton product / scale rounding, linear ops, saturation, output register
   qau_alu #(
      .FRAC_BITS (FRAC_BITS)
   ) u_alu (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_ready  (div_ready),
      .in_ctx    (div_ctx),
      .in_nres   (div_nres),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_r     (alu_r),
      .out_sat   (rsp_bus.saturated),
      .out_zn    (rsp_bus.zero_norm)
   );

   assign rsp_bus.r_w = alu_r[0];
   assign rsp_bus.r_x = alu_r[1];
   assign rsp_bus.r_y = alu_r[2];
   assign rsp_bus.r_z = alu_r[3];

endmodule
`default_nettype wire
